>>> rtl/core/assert_macros.svh
// assertion helpers, included by the integrator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked on every rising edge, suspended while reset is asserted
`define ASSERT_AT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// checked on every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> rtl/core/cddi_pkg.sv
`default_nettype none

package cddi_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAIN_W = 31;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned FRAC_W = 16;
  // operand to the multiplier: a difference of two data words
  localparam int unsigned OPND_W = DATA_W + 1;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned RND_W  = PROD_W - FRAC_W;
  // data word plus two rounded products
  localparam int unsigned ACC_W  = RND_W + 2;

  typedef enum logic [1:0] {
    CFG_STEP_GAIN         = 2'd0,
    CFG_HALF_STEP_SQ_GAIN = 2'd1,
    CFG_HALF_STEP         = 2'd2,
    CFG_INV_HALF_STEP     = 2'd3
  } cfg_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_PREDICT  = 3'd0,
    REQ_CORRECT  = 3'd1,
    REQ_FIX      = 3'd2,
    REQ_SET_DISP = 3'd3,
    REQ_SET_VEL  = 3'd4,
    REQ_SET_ACC  = 3'd5
  } req_e;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [IDX_W-1:0]         dof_index;
    logic                     active_flag;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] disp_out;
    logic signed [DATA_W-1:0] vel_out;
    logic signed [DATA_W-1:0] acc_out;
    logic                     saturated;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/core/cddi_ram.sv
`default_nettype none

module cddi_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/cddi_mul.sv
`default_nettype none

module cddi_mul (
  input  logic                                clk_i,
  input  logic signed [cddi_pkg::OPND_W-1:0]  x_i,
  input  logic        [cddi_pkg::GAIN_W-1:0]  g_i,
  output logic signed [cddi_pkg::RND_W-1:0]   rnd_o
);

  logic signed [cddi_pkg::OPND_W+cddi_pkg::GAIN_W:0] prod_d;
  logic signed [cddi_pkg::PROD_W-1:0]                prod_q;
  logic signed [cddi_pkg::PROD_W-1:0]                biased;

  // signed operand times unsigned gain, exact
  assign prod_d = x_i * $signed({1'b0, g_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d[cddi_pkg::PROD_W-1:0];
  end

  // add one half lsb, then floor by dropping the fraction
  assign biased = prod_q + (cddi_pkg::PROD_W'(1) <<< (cddi_pkg::FRAC_W - 1));
  assign rnd_o  = biased[cddi_pkg::PROD_W-1:cddi_pkg::FRAC_W];

endmodule

`default_nettype wire

>>> rtl/core/central_difference_dof_integrator.sv
`default_nettype none
`include "assert_macros.svh"

// Explicit central-difference integrator over NUM_DOFS entries of displacement,
// velocity and acceleration in signed Q16.16, held in one single-port-write RAM
// word per entry. One transaction at a time: after acceptance the index is reduced
// modulo NUM_DOFS by a reciprocal multiplication (S_MOD), the entry is read
// (S_READ, S_LOAD), each gain product passes S_MUL and S_ACC on the single shared
// multiplier, and the result is written back in S_WRITE. A transaction needs 3
// products for predict, 1 for active correct, set velocity and set acceleration,
// 0 otherwise; a new one is accepted only once the block is back in S_IDLE.
// The result sits in an output register, so the next transaction can be accepted
// while it waits; the write-back is held for as long as an earlier result is still
// stalled in that register. After reset the RAM is cleared one entry a cycle, each
// of the NUM_DOFS entries, and no transaction is accepted until then; configuration
// writes are taken at any time but must only be issued while the block is idle.
module central_difference_dof_integrator #(
  parameter int unsigned NUM_DOFS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [cddi_pkg::GAIN_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cddi_pkg::in_t                  in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cddi_pkg::out_t                 out_o
);

  localparam int unsigned AW     = (NUM_DOFS > 1) ? $clog2(NUM_DOFS) : 1;
  localparam int unsigned DW     = cddi_pkg::DATA_W;
  localparam int unsigned WORD_W = 3 * DW;
  localparam int unsigned ACC_W  = cddi_pkg::ACC_W;
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned QUOT_W   = cddi_pkg::IDX_W + RECIP_SH;
  // rounded-up reciprocal, exact quotient for every 10-bit index
  localparam logic [RECIP_W-1:0] RecipMul =
    RECIP_W'((2 ** RECIP_SH + NUM_DOFS - 1) / NUM_DOFS);
  localparam logic [AW-1:0] ClrLast = AW'(NUM_DOFS - 1);
  localparam logic signed [ACC_W-1:0] AccMax = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] AccMin = ACC_W'(-64'sd2147483648);
  localparam logic signed [DW-1:0] DataMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DataMin = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_LOAD  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_ACC   = 8'b0100_0000,
    S_WRITE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [cddi_pkg::GAIN_W-1:0] sg_q, hssg_q, hs_q, ihs_q;

  logic [cddi_pkg::REQ_W-1:0]    req_q, req_d;
  logic                          active_q, active_d;
  logic signed [DW-1:0]          val_q, val_d;
  logic [cddi_pkg::IDX_W-1:0]    rem_q, rem_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic [1:0]                    op_q, op_d;
  logic signed [DW-1:0]          d_q, d_d, v_q, v_d, a_q, a_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic signed [cddi_pkg::OPND_W-1:0] x_q, x_d;
  logic [cddi_pkg::GAIN_W-1:0]   g_q, g_d;
  logic                          sat_q, sat_d;
  logic                          out_valid_q, out_valid_d;
  cddi_pkg::out_t                out_q, out_d;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, addr;
  logic [WORD_W-1:0]             ram_wdata, ram_rdata;
  logic signed [DW-1:0]          d_ld, v_ld, a_ld;
  logic [QUOT_W-1:0]             quot_prod, quot_back;
  logic [cddi_pkg::IDX_W-1:0]    quot;
  logic signed [cddi_pkg::RND_W-1:0] rnd;
  logic signed [ACC_W-1:0]       acc_sum;
  logic                          ovf;
  logic signed [DW-1:0]          sat_val;
  logic                          out_load;

  assign addr    = AW'(rem_q);
  assign d_ld    = ram_rdata[3*DW-1:2*DW];
  assign v_ld    = ram_rdata[2*DW-1:DW];
  assign a_ld    = ram_rdata[DW-1:0];

  // index modulo NUM_DOFS: quotient by reciprocal, then subtract it back out
  assign quot_prod = QUOT_W'(rem_q) * QUOT_W'(RecipMul);
  assign quot      = quot_prod[QUOT_W-1:RECIP_SH];
  assign quot_back = QUOT_W'(quot) * QUOT_W'(NUM_DOFS);

  // accumulate the rounded product and clamp to the data range
  assign acc_sum = acc_q + ACC_W'(rnd);
  always_comb begin
    ovf     = 1'b0;
    sat_val = acc_sum[DW-1:0];
    if (acc_sum > AccMax) begin
      ovf     = 1'b1;
      sat_val = DataMax;
    end else if (acc_sum < AccMin) begin
      ovf     = 1'b1;
      sat_val = DataMin;
    end
  end

  cddi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_DOFS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  cddi_mul u_mul (
    .clk_i (clk_i),
    .x_i   (x_q),
    .g_i   (g_q),
    .rnd_o (rnd)
  );

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    active_d  = active_q;
    val_d     = val_q;
    rem_d     = rem_q;
    clr_d     = clr_q;
    op_d      = op_q;
    d_d       = d_q;
    v_d       = v_q;
    a_d       = a_q;
    acc_d     = acc_q;
    x_d       = x_q;
    g_d       = g_q;
    sat_d     = sat_q;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = {d_q, v_q, a_q};
    out_load  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_i.req_type;
          active_d = in_i.active_flag;
          val_d    = in_i.value;
          rem_d    = in_i.dof_index;
          state_d  = S_MOD;
        end
      end
      S_MOD: begin
        rem_d   = rem_q - quot_back[cddi_pkg::IDX_W-1:0];
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        d_d     = d_ld;
        v_d     = v_ld;
        a_d     = a_ld;
        sat_d   = 1'b0;
        op_d    = 2'd0;
        state_d = S_WRITE;
        case (req_q)
          cddi_pkg::REQ_PREDICT: begin
            acc_d   = ACC_W'(d_ld);
            x_d     = cddi_pkg::OPND_W'(v_ld);
            g_d     = sg_q;
            state_d = S_MUL;
          end
          cddi_pkg::REQ_CORRECT: begin
            if (active_q) begin
              acc_d   = ACC_W'(v_ld);
              x_d     = cddi_pkg::OPND_W'(val_q);
              g_d     = hs_q;
              a_d     = val_q;
              state_d = S_MUL;
            end
          end
          cddi_pkg::REQ_FIX: begin
            d_d = '0;
            v_d = '0;
            a_d = '0;
          end
          cddi_pkg::REQ_SET_DISP: begin
            d_d = val_q;
            a_d = '0;
          end
          cddi_pkg::REQ_SET_VEL: begin
            acc_d   = '0;
            x_d     = cddi_pkg::OPND_W'(val_q) - cddi_pkg::OPND_W'(v_ld);
            g_d     = ihs_q;
            v_d     = val_q;
            state_d = S_MUL;
          end
          cddi_pkg::REQ_SET_ACC: begin
            acc_d   = ACC_W'(v_ld);
            x_d     = cddi_pkg::OPND_W'(val_q);
            g_d     = hs_q;
            a_d     = val_q;
            state_d = S_MUL;
          end
          default: begin
            state_d = S_WRITE;
          end
        endcase
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        state_d = S_WRITE;
        case (req_q)
          cddi_pkg::REQ_PREDICT: begin
            if (op_q == 2'd0) begin
              // displacement sum stays exact until both products are in
              acc_d   = acc_sum;
              x_d     = cddi_pkg::OPND_W'(a_q);
              g_d     = hssg_q;
              op_d    = 2'd1;
              state_d = S_MUL;
            end else if (op_q == 2'd1) begin
              d_d     = sat_val;
              sat_d   = sat_q | ovf;
              acc_d   = ACC_W'(v_q);
              x_d     = cddi_pkg::OPND_W'(a_q);
              g_d     = hs_q;
              op_d    = 2'd2;
              state_d = S_MUL;
            end else begin
              v_d   = sat_val;
              sat_d = sat_q | ovf;
            end
          end
          cddi_pkg::REQ_SET_VEL: begin
            a_d   = sat_val;
            sat_d = sat_q | ovf;
          end
          default: begin
            v_d   = sat_val;
            sat_d = sat_q | ovf;
          end
        endcase
      end
      S_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          ram_we   = 1'b1;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_comb begin
    out_d = out_q;
    if (out_load) begin
      out_d.disp_out  = d_q;
      out_d.vel_out   = v_q;
      out_d.acc_out   = a_q;
      out_d.saturated = sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      op_q        <= '0;
      out_valid_q <= 1'b0;
      sg_q        <= '0;
      hssg_q      <= '0;
      hs_q        <= '0;
      ihs_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cddi_pkg::CFG_STEP_GAIN:         sg_q   <= cfg_data_i;
          cddi_pkg::CFG_HALF_STEP_SQ_GAIN: hssg_q <= cfg_data_i;
          cddi_pkg::CFG_HALF_STEP:         hs_q   <= cfg_data_i;
          cddi_pkg::CFG_INV_HALF_STEP:     ihs_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    active_q <= active_d;
    val_q    <= val_d;
    rem_q    <= rem_d;
    d_q      <= d_d;
    v_q      <= v_d;
    a_q      <= a_d;
    acc_q    <= acc_d;
    x_q      <= x_d;
    g_q      <= g_d;
    sat_q    <= sat_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ASSERT_AT(a_index_reduced, clk_i, rst_ni, (state_q == S_READ) |-> (rem_q < NUM_DOFS))
  `ASSERT_AT(a_extra_products_only_predict, clk_i, rst_ni, (state_q == S_MUL && op_q != 2'd0) |-> (req_q == cddi_pkg::REQ_PREDICT))
  `ASSERT_AT(a_clear_then_idle, clk_i, rst_ni, (state_q == S_CLEAR && clr_q == ClrLast) |=> (state_q == S_IDLE))
  `ASSERT_AT(a_writeback_gives_result, clk_i, rst_ni, (state_q == S_WRITE && (!out_valid_o || !out_stall_i)) |=> (out_valid_o && state_q == S_IDLE))
  `ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire

>>> bench/central_difference_dof_integrator_tb.sv
`default_nettype none

module central_difference_dof_integrator_tb;

  localparam int unsigned NUM_DOFS    = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned RANDOM_PER_PHASE = 115;
  localparam int unsigned DRAIN_CYCLES = 30;

  // request codes the block does not define
  localparam logic [cddi_pkg::REQ_W-1:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [cddi_pkg::REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

  localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16_MIN = -Q16_MAX - 1;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [1:0]                  cfg_idx_i = '0;
  logic [cddi_pkg::GAIN_W-1:0] cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  cddi_pkg::in_t               in_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  cddi_pkg::out_t              out_o;

  central_difference_dof_integrator #(
    .NUM_DOFS(NUM_DOFS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow state of the integrator
  int     disp_mem [NUM_DOFS];
  int     vel_mem  [NUM_DOFS];
  int     acc_mem  [NUM_DOFS];
  longint step_gain_q;
  longint half_sq_gain_q;
  longint half_step_q;
  longint inv_half_step_q;

  cddi_pkg::in_t  pending_items[$];
  cddi_pkg::out_t predicted_states[$];
  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        item_taken = 1'b0;

  function automatic longint mul_round(longint x, longint g);
    return (x * g + 64'sd32768) >>> 16;
  endfunction

  function automatic bit out_of_range(longint x);
    return (x > Q16_MAX) || (x < Q16_MIN);
  endfunction

  function automatic int clamp_q16(longint x);
    if (x > Q16_MAX) return int'(Q16_MAX);
    if (x < Q16_MIN) return int'(Q16_MIN);
    return int'(x);
  endfunction

  function automatic cddi_pkg::out_t integrate_entry(cddi_pkg::in_t it);
    int unsigned    idx;
    int             raw;
    longint         d, v, a, val;
    bit             clamped;
    cddi_pkg::out_t r;
    idx = it.dof_index % NUM_DOFS;
    raw = it.value;
    val = longint'(raw);
    d = longint'(disp_mem[idx]);
    v = longint'(vel_mem[idx]);
    a = longint'(acc_mem[idx]);
    clamped = 1'b0;
    case (it.req_type)
      cddi_pkg::REQ_PREDICT: begin
        // displacement uses the old velocity
        d = d + mul_round(v, step_gain_q) + mul_round(a, half_sq_gain_q);
        clamped |= out_of_range(d);
        d = clamp_q16(d);
        v = v + mul_round(a, half_step_q);
        clamped |= out_of_range(v);
        v = clamp_q16(v);
      end
      cddi_pkg::REQ_CORRECT: begin
        if (it.active_flag) begin
          v = v + mul_round(val, half_step_q);
          clamped |= out_of_range(v);
          v = clamp_q16(v);
          a = val;
        end
      end
      cddi_pkg::REQ_FIX: begin
        d = 0;
        v = 0;
        a = 0;
      end
      cddi_pkg::REQ_SET_DISP: begin
        d = val;
        a = 0;
      end
      cddi_pkg::REQ_SET_VEL: begin
        a = mul_round(val - v, inv_half_step_q);
        clamped |= out_of_range(a);
        a = clamp_q16(a);
        v = val;
      end
      cddi_pkg::REQ_SET_ACC: begin
        a = val;
        v = v + mul_round(val, half_step_q);
        clamped |= out_of_range(v);
        v = clamp_q16(v);
      end
      default: ;
    endcase
    disp_mem[idx] = int'(d);
    vel_mem[idx]  = int'(v);
    acc_mem[idx]  = int'(a);
    r.disp_out  = disp_mem[idx];
    r.vel_out   = vel_mem[idx];
    r.acc_out   = acc_mem[idx];
    r.saturated = clamped;
    return r;
  endfunction

  function automatic logic [cddi_pkg::DATA_W-1:0] random_q16();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      5:       return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      6:       return '0;
      default: return $urandom_range(0, 4) - 2;
    endcase
  endfunction

  function automatic cddi_pkg::in_t random_item();
    cddi_pkg::in_t it;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      it.req_type = cddi_pkg::REQ_PREDICT;
    else if (pick < 55) it.req_type = cddi_pkg::REQ_CORRECT;
    else if (pick < 62) it.req_type = cddi_pkg::REQ_FIX;
    else if (pick < 72) it.req_type = cddi_pkg::REQ_SET_DISP;
    else if (pick < 82) it.req_type = cddi_pkg::REQ_SET_VEL;
    else if (pick < 94) it.req_type = cddi_pkg::REQ_SET_ACC;
    else if (pick < 97) it.req_type = REQ_UNKNOWN_LO;
    else                it.req_type = REQ_UNKNOWN_HI;
    // mostly a small working set so entries evolve over many steps
    pick = $urandom_range(0, 9);
    if (pick < 6)      it.dof_index = cddi_pkg::IDX_W'($urandom_range(0, 7));
    else if (pick < 9) it.dof_index = cddi_pkg::IDX_W'($urandom_range(0, NUM_DOFS - 1));
    else it.dof_index = cddi_pkg::IDX_W'($urandom_range(0, 1) ? 0 : NUM_DOFS - 1);
    it.active_flag = ($urandom_range(0, 9) < 8);
    it.value = random_q16();
    return it;
  endfunction

  task automatic queue_item(logic [cddi_pkg::REQ_W-1:0] req, int unsigned idx, logic act,
                            logic [cddi_pkg::DATA_W-1:0] val);
    cddi_pkg::in_t it;
    it.req_type    = req;
    it.dof_index   = cddi_pkg::IDX_W'(idx);
    it.active_flag = act;
    it.value       = val;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(cddi_pkg::cfg_e idx, logic [cddi_pkg::GAIN_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cddi_pkg::CFG_STEP_GAIN:         step_gain_q     = longint'(data);
      cddi_pkg::CFG_HALF_STEP_SQ_GAIN: half_sq_gain_q  = longint'(data);
      cddi_pkg::CFG_HALF_STEP:         half_step_q     = longint'(data);
      cddi_pkg::CFG_INV_HALF_STEP:     inv_half_step_q = longint'(data);
      default: ;
    endcase
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    if (!in_valid_i || item_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_i       <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall density changes from run to run
  int unsigned stall_run_left = 0;
  int unsigned stall_pct = 0;
  always @(negedge clk_i) begin
    if (stall_run_left == 0) begin
      stall_run_left = $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        2:       stall_pct = 70;
        default: stall_pct = 95;
      endcase
    end
    stall_run_left--;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // input transaction: update the shadow state
  always @(posedge clk_i) begin
    item_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) predicted_states.push_back(integrate_entry(in_i));
  end

  // output transaction: compare with the oldest prediction
  always @(posedge clk_i) begin
    cddi_pkg::out_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (predicted_states.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result d=%h v=%h a=%h sat=%b",
                   out_o.disp_out, out_o.vel_out, out_o.acc_out, out_o.saturated);
      end else begin
        want = predicted_states.pop_front();
        if (out_o.disp_out !== want.disp_out || out_o.vel_out !== want.vel_out ||
            out_o.acc_out !== want.acc_out || out_o.saturated !== want.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp d=%h v=%h a=%h sat=%b got d=%h v=%h a=%h sat=%b",
                     want.disp_out, want.vel_out, want.acc_out, want.saturated,
                     out_o.disp_out, out_o.vel_out, out_o.acc_out, out_o.saturated);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [cddi_pkg::GAIN_W-1:0] gains [4];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: gains = '{31'd65536, 31'd32768, 31'd32768, 31'd131072};
        1: gains = '{31'd655, 31'd3, 31'd328, 31'd13107200};
        2: gains = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
        3: gains = '{31'd0, 31'd0, 31'd0, 31'd0};
        4: for (int g = 0; g < 4; g++)
             gains[g] = cddi_pkg::GAIN_W'($urandom_range(0, 32'h0004_0000));
        default: for (int g = 0; g < 4; g++) gains[g] = cddi_pkg::GAIN_W'($urandom);
      endcase
      for (int g = 0; g < 4; g++) write_reg(cddi_pkg::cfg_e'(g), gains[g]);
      if (phase == 0) begin
        // dt of one: hand-checkable steps, ties, clamping, both index ends
        queue_item(cddi_pkg::REQ_PREDICT,  0,    1'b1, 32'h0000_0000);
        queue_item(cddi_pkg::REQ_SET_DISP, 0,    1'b0, 32'h0001_0000);
        queue_item(cddi_pkg::REQ_SET_VEL,  0,    1'b0, 32'h0002_0000);
        queue_item(cddi_pkg::REQ_PREDICT,  0,    1'b0, 32'h0000_0000);
        queue_item(cddi_pkg::REQ_CORRECT,  0,    1'b1, 32'hFFFF_0000);
        queue_item(cddi_pkg::REQ_CORRECT,  0,    1'b0, 32'h7FFF_FFFF);
        queue_item(cddi_pkg::REQ_SET_ACC,  1023, 1'b1, 32'h7FFF_FFFF);
        queue_item(cddi_pkg::REQ_SET_ACC,  1023, 1'b1, 32'h7FFF_FFFF);
        queue_item(cddi_pkg::REQ_PREDICT,  1023, 1'b1, 32'h0000_0000);
        queue_item(cddi_pkg::REQ_SET_VEL,  1023, 1'b0, 32'h8000_0000);
        queue_item(cddi_pkg::REQ_SET_VEL,  1023, 1'b1, 32'h7FFF_FFFF);
        queue_item(cddi_pkg::REQ_SET_DISP, 1023, 1'b1, 32'h8000_0000);
        queue_item(cddi_pkg::REQ_CORRECT,  1023, 1'b1, 32'h8000_0000);
        queue_item(cddi_pkg::REQ_PREDICT,  1023, 1'b0, 32'h0000_0000);
        queue_item(cddi_pkg::REQ_FIX,      1023, 1'b1, 32'hFFFF_FFFF);
        queue_item(REQ_UNKNOWN_LO,         0,    1'b1, 32'h7FFF_FFFF);
        queue_item(REQ_UNKNOWN_HI,         1023, 1'b0, 32'h8000_0000);
        // rounding ties go toward plus infinity
        queue_item(cddi_pkg::REQ_SET_ACC,  5,    1'b0, 32'hFFFF_FFFD);
        queue_item(cddi_pkg::REQ_SET_ACC,  6,    1'b0, 32'h0000_0001);
        queue_item(cddi_pkg::REQ_SET_ACC,  6,    1'b0, 32'hFFFF_FFFF);
        queue_item(cddi_pkg::REQ_CORRECT,  512,  1'b1, 32'h8000_0000);
        queue_item(cddi_pkg::REQ_PREDICT,  512,  1'b1, 32'h0000_0000);
        queue_item(cddi_pkg::REQ_SET_DISP, 512,  1'b0, 32'h7FFF_FFFF);
        queue_item(cddi_pkg::REQ_PREDICT,  512,  1'b0, 32'h0000_0000);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_items.push_back(random_item());
        items_queued++;
      end
      while (results_seen != items_queued) @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && predicted_states.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/cddi_pkg.sv
rtl/core/cddi_ram.sv
rtl/core/cddi_mul.sv
rtl/core/central_difference_dof_integrator.sv
bench/central_difference_dof_integrator_tb.sv
